[rtl/jpd_pkg.sv]
`timescale 1ns / 1ps

package jpd_pkg;

    localparam int NUM_JOINTS = 7;
    localparam int FRAC_BITS  = 16;

    localparam int JOINT_W  = 3;
    localparam int DATA_W   = 32;
    localparam int TORQUE_W = 24;
    localparam int IDX_W    = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    // Error is the difference of two signed words; gains are widened by one zero bit.
    localparam int ERR_W  = DATA_W + 1;
    localparam int PROD_W = 2 * ERR_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int WANT_W = SUM_W - FRAC_BITS + 1;
    localparam int DIFF_W = WANT_W + 1;

    // Per-joint absolute limits in Nm; step is limit / 20, rounded to nearest.
    localparam int LIMIT_BIG_NM   = 108;
    localparam int LIMIT_MID_NM   = 66;
    localparam int LIMIT_SMALL_NM = 19;
    localparam int STEP_ROUND     = 10;
    localparam int STEP_DIV       = 20;

    localparam logic signed [TORQUE_W-1:0] LIM_BIG_Q   =
        TORQUE_W'(LIMIT_BIG_NM * (2 ** FRAC_BITS));
    localparam logic signed [TORQUE_W-1:0] LIM_MID_Q   =
        TORQUE_W'(LIMIT_MID_NM * (2 ** FRAC_BITS));
    localparam logic signed [TORQUE_W-1:0] LIM_SMALL_Q =
        TORQUE_W'(LIMIT_SMALL_NM * (2 ** FRAC_BITS));

    localparam logic signed [TORQUE_W-1:0] STEP_BIG_Q   =
        TORQUE_W'((LIMIT_BIG_NM * (2 ** FRAC_BITS) + STEP_ROUND) / STEP_DIV);
    localparam logic signed [TORQUE_W-1:0] STEP_MID_Q   =
        TORQUE_W'((LIMIT_MID_NM * (2 ** FRAC_BITS) + STEP_ROUND) / STEP_DIV);
    localparam logic signed [TORQUE_W-1:0] STEP_SMALL_Q =
        TORQUE_W'((LIMIT_SMALL_NM * (2 ** FRAC_BITS) + STEP_ROUND) / STEP_DIV);

    typedef struct packed {
        logic [JOINT_W-1:0]       joint_index;
        logic                     has_command;
        logic [DATA_W-1:0]        stiffness_gain;
        logic [DATA_W-1:0]        damping_gain;
        logic signed [DATA_W-1:0] target_position;
        logic signed [DATA_W-1:0] target_velocity;
        logic signed [DATA_W-1:0] feedforward_torque;
        logic signed [DATA_W-1:0] measured_position;
        logic signed [DATA_W-1:0] measured_velocity;
    } cmd_t;

    typedef struct packed {
        logic [JOINT_W-1:0]       joint;
        logic                     in_range;
        logic signed [WANT_W-1:0] want;
    } pd_item_t;

    typedef struct packed {
        logic                       en;
        logic [IDX_W-1:0]           addr;
        logic signed [TORQUE_W-1:0] data;
    } mem_wr_t;

    function automatic logic signed [TORQUE_W-1:0] limit_of(input logic [IDX_W-1:0] idx);
        logic signed [TORQUE_W-1:0] lim;
        case (idx)
            IDX_W'(0), IDX_W'(1): lim = LIM_BIG_Q;
            IDX_W'(2), IDX_W'(3): lim = LIM_MID_Q;
            default:              lim = LIM_SMALL_Q;
        endcase
        return lim;
    endfunction

    function automatic logic signed [TORQUE_W-1:0] step_of(input logic [IDX_W-1:0] idx);
        logic signed [TORQUE_W-1:0] stp;
        case (idx)
            IDX_W'(0), IDX_W'(1): stp = STEP_BIG_Q;
            IDX_W'(2), IDX_W'(3): stp = STEP_MID_Q;
            default:              stp = STEP_SMALL_Q;
        endcase
        return stp;
    endfunction

endpackage

[rtl/jpd_prev_mem.sv]
`timescale 1ns / 1ps

module jpd_prev_mem (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                rd_en,
    input  logic [jpd_pkg::IDX_W-1:0]           rd_addr,
    output logic signed [jpd_pkg::TORQUE_W-1:0] rd_data,
    input  jpd_pkg::mem_wr_t                    wr
);

    logic signed [jpd_pkg::TORQUE_W-1:0] mem_reg [jpd_pkg::NUM_JOINTS];
    logic [jpd_pkg::NUM_JOINTS-1:0]      valid_reg;
    logic signed [jpd_pkg::TORQUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    // Entries never written since reset read as zero torque.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // Bypass a write to the same joint landing on the read edge.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr.en && (wr.addr == rd_addr)) begin
                rd_data_reg <= wr.data;
            end else if (valid_reg[rd_addr]) begin
                rd_data_reg <= mem_reg[rd_addr];
            end else begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/jpd_pd_calc.sv]
`timescale 1ns / 1ps

module jpd_pd_calc (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  jpd_pkg::cmd_t       in_cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output jpd_pkg::pd_item_t   out_item
);

    // Stage 1: errors
    logic                                  s1_v_reg;
    logic [jpd_pkg::JOINT_W-1:0]           s1_joint_reg;
    logic                                  s1_cmd_reg;
    logic signed [jpd_pkg::ERR_W-1:0]      s1_kp_reg;
    logic signed [jpd_pkg::ERR_W-1:0]      s1_kd_reg;
    logic signed [jpd_pkg::ERR_W-1:0]      s1_ep_reg;
    logic signed [jpd_pkg::ERR_W-1:0]      s1_ev_reg;
    logic signed [jpd_pkg::DATA_W-1:0]     s1_ff_reg;

    // Stage 2: products
    logic                                  s2_v_reg;
    logic [jpd_pkg::JOINT_W-1:0]           s2_joint_reg;
    logic                                  s2_cmd_reg;
    logic signed [jpd_pkg::PROD_W-1:0]     s2_pp_reg;
    logic signed [jpd_pkg::PROD_W-1:0]     s2_pv_reg;
    logic signed [jpd_pkg::DATA_W-1:0]     s2_ff_reg;

    // Stage 3: desired torque
    logic                                  s3_v_reg;
    jpd_pkg::pd_item_t                     s3_item_reg;

    logic s1_ready, s2_ready, s3_ready;

    logic signed [jpd_pkg::ERR_W-1:0]      ep_next;
    logic signed [jpd_pkg::ERR_W-1:0]      ev_next;
    logic signed [jpd_pkg::PROD_W-1:0]     pp_next;
    logic signed [jpd_pkg::PROD_W-1:0]     pv_next;
    logic signed [jpd_pkg::SUM_W-1:0]      sum_next;
    logic signed [jpd_pkg::WANT_W-2:0]     scaled_next;
    logic signed [jpd_pkg::WANT_W-1:0]     want_next;
    jpd_pkg::pd_item_t                     item_next;

    assign s3_ready = !s3_v_reg || out_ready;
    assign s2_ready = !s2_v_reg || s3_ready;
    assign s1_ready = !s1_v_reg || s2_ready;
    assign in_ready = s1_ready;

    assign ep_next = jpd_pkg::ERR_W'(in_cmd.target_position)
                   - jpd_pkg::ERR_W'(in_cmd.measured_position);
    assign ev_next = jpd_pkg::ERR_W'(in_cmd.target_velocity)
                   - jpd_pkg::ERR_W'(in_cmd.measured_velocity);

    assign pp_next = s1_kp_reg * s1_ep_reg;
    assign pv_next = s1_kd_reg * s1_ev_reg;

    // Floor shift of the exact sum, then add feedforward.
    assign sum_next    = jpd_pkg::SUM_W'(s2_pp_reg) + jpd_pkg::SUM_W'(s2_pv_reg);
    assign scaled_next = sum_next[jpd_pkg::SUM_W-1:jpd_pkg::FRAC_BITS];
    assign want_next   = jpd_pkg::WANT_W'(scaled_next) + jpd_pkg::WANT_W'(s2_ff_reg);

    always_comb begin
        item_next.joint    = s2_joint_reg;
        item_next.in_range = (s2_joint_reg < jpd_pkg::JOINT_W'(jpd_pkg::NUM_JOINTS));
        item_next.want     = s2_cmd_reg ? want_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_v_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_ready) begin
                s3_v_reg <= s2_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_joint_reg <= in_cmd.joint_index;
            s1_cmd_reg   <= in_cmd.has_command;
            s1_kp_reg    <= $signed({1'b0, in_cmd.stiffness_gain});
            s1_kd_reg    <= $signed({1'b0, in_cmd.damping_gain});
            s1_ep_reg    <= ep_next;
            s1_ev_reg    <= ev_next;
            s1_ff_reg    <= in_cmd.feedforward_torque;
        end
        if (s2_ready && s1_v_reg) begin
            s2_joint_reg <= s1_joint_reg;
            s2_cmd_reg   <= s1_cmd_reg;
            s2_pp_reg    <= pp_next;
            s2_pv_reg    <= pv_next;
            s2_ff_reg    <= s1_ff_reg;
        end
        if (s3_ready && s2_v_reg) begin
            s3_item_reg <= item_next;
        end
    end

    assign out_valid = s3_v_reg;
    assign out_item  = s3_item_reg;

endmodule

[rtl/jpd_slew_clamp.sv]
`timescale 1ns / 1ps

module jpd_slew_clamp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  jpd_pkg::pd_item_t                   in_item,
    input  logic signed [jpd_pkg::TORQUE_W-1:0] prev_torque,
    output jpd_pkg::mem_wr_t                    wr,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [jpd_pkg::JOINT_W-1:0]         out_joint,
    output logic signed [jpd_pkg::TORQUE_W-1:0] out_torque
);

    logic                                a_v_reg;
    jpd_pkg::pd_item_t                   a_item_reg;
    logic                                o_v_reg;
    logic [jpd_pkg::JOINT_W-1:0]         o_joint_reg;
    logic signed [jpd_pkg::TORQUE_W-1:0] o_torque_reg;

    logic a_ready, o_ready;

    logic [jpd_pkg::IDX_W-1:0]           idx;
    logic signed [jpd_pkg::DIFF_W-1:0]   want_x;
    logic signed [jpd_pkg::DIFF_W-1:0]   prev_x;
    logic signed [jpd_pkg::DIFF_W-1:0]   step_x;
    logic signed [jpd_pkg::DIFF_W-1:0]   lim_x;
    logic signed [jpd_pkg::DIFF_W-1:0]   diff;
    logic signed [jpd_pkg::DIFF_W-1:0]   slewed;
    logic signed [jpd_pkg::DIFF_W-1:0]   clamped;
    logic signed [jpd_pkg::TORQUE_W-1:0] torque_next;

    assign o_ready  = !o_v_reg || out_ready;
    assign a_ready  = !a_v_reg || o_ready;
    assign in_ready = a_ready;

    assign idx    = a_item_reg.joint[jpd_pkg::IDX_W-1:0];
    assign want_x = jpd_pkg::DIFF_W'(a_item_reg.want);
    assign prev_x = jpd_pkg::DIFF_W'(prev_torque);
    assign step_x = jpd_pkg::DIFF_W'(jpd_pkg::step_of(idx));
    assign lim_x  = jpd_pkg::DIFF_W'(jpd_pkg::limit_of(idx));
    assign diff   = want_x - prev_x;

    always_comb begin
        if (diff > step_x) begin
            slewed = prev_x + step_x;
        end else if (diff < -step_x) begin
            slewed = prev_x - step_x;
        end else begin
            slewed = want_x;
        end

        if (slewed > lim_x) begin
            clamped = lim_x;
        end else if (slewed < -lim_x) begin
            clamped = -lim_x;
        end else begin
            clamped = slewed;
        end

        // Drop joints past the table: zero torque, no state update.
        torque_next = a_item_reg.in_range ? clamped[jpd_pkg::TORQUE_W-1:0] : '0;
    end

    always_comb begin
        wr.en   = a_v_reg && o_ready && a_item_reg.in_range;
        wr.addr = idx;
        wr.data = torque_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_v_reg <= in_valid;
            end
            if (o_ready) begin
                o_v_reg <= a_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_item_reg <= in_item;
        end
        if (o_ready && a_v_reg) begin
            o_joint_reg  <= a_item_reg.joint;
            o_torque_reg <= torque_next;
        end
    end

    assign out_valid  = o_v_reg;
    assign out_joint  = o_joint_reg;
    assign out_torque = o_torque_reg;

endmodule

[rtl/joint_pd_torque_slew_clamp_core.sv]
`timescale 1ns / 1ps
// Pipeline: five register stages: errors, products and desired torque, then the
// previous-torque read and the output register. Throughput: one item per cycle unless
// m_ready stalls the output; the previous-torque memory bypasses a write to the same
// joint, so back-to-back items for one joint need no stall.
// Reset: aresetn clears all pipeline valids and marks every joint's previous torque as zero.

module joint_pd_torque_slew_clamp_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [jpd_pkg::JOINT_W-1:0]         s_joint_index,
    input  logic                                s_has_command,
    input  logic [jpd_pkg::DATA_W-1:0]          s_stiffness_gain,
    input  logic [jpd_pkg::DATA_W-1:0]          s_damping_gain,
    input  logic signed [jpd_pkg::DATA_W-1:0]   s_target_position,
    input  logic signed [jpd_pkg::DATA_W-1:0]   s_target_velocity,
    input  logic signed [jpd_pkg::DATA_W-1:0]   s_feedforward_torque,
    input  logic signed [jpd_pkg::DATA_W-1:0]   s_measured_position,
    input  logic signed [jpd_pkg::DATA_W-1:0]   s_measured_velocity,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [jpd_pkg::JOINT_W-1:0]         m_joint_number,
    output logic signed [jpd_pkg::TORQUE_W-1:0] m_torque_command
);

    jpd_pkg::cmd_t                       cmd;
    jpd_pkg::pd_item_t                   pd_item;
    jpd_pkg::mem_wr_t                    wr;
    logic                                pd_valid;
    logic                                sc_ready;
    logic                                rd_en;
    logic [jpd_pkg::IDX_W-1:0]           rd_addr;
    logic signed [jpd_pkg::TORQUE_W-1:0] prev_torque;

    always_comb begin
        cmd.joint_index        = s_joint_index;
        cmd.has_command        = s_has_command;
        cmd.stiffness_gain     = s_stiffness_gain;
        cmd.damping_gain       = s_damping_gain;
        cmd.target_position    = s_target_position;
        cmd.target_velocity    = s_target_velocity;
        cmd.feedforward_torque = s_feedforward_torque;
        cmd.measured_position  = s_measured_position;
        cmd.measured_velocity  = s_measured_velocity;
    end

    jpd_pd_calc u_pd_calc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_cmd    (cmd),
        .out_valid (pd_valid),
        .out_ready (sc_ready),
        .out_item  (pd_item)
    );

    // Read the joint's previous torque as the item enters the slew stage.
    assign rd_en   = pd_valid && sc_ready;
    assign rd_addr = pd_item.in_range ? pd_item.joint[jpd_pkg::IDX_W-1:0] : '0;

    jpd_prev_mem u_prev_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (prev_torque),
        .wr      (wr)
    );

    jpd_slew_clamp u_slew_clamp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (pd_valid),
        .in_ready    (sc_ready),
        .in_item     (pd_item),
        .prev_torque (prev_torque),
        .wr          (wr),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_joint   (m_joint_number),
        .out_torque  (m_torque_command)
    );

endmodule
